// ===== rtl/core/swld_pkg.sv =====
package swld_pkg;

    localparam logic [31:0] SYNC_WORD     = 32'h55AA_55AA;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] MAXLEN_RESET  = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    localparam int CFG_W = 16;

    localparam logic CFG_TIMEOUT_TICKS = 1'b0;
    localparam logic CFG_MAX_LENGTH    = 1'b1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        RK_PAYLOAD  = 2'd0,
        RK_EMPTY    = 2'd1,
        RK_OVERSIZE = 2'd2,
        RK_TIMEOUT  = 2'd3
    } rkind_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       valid;
        rkind_t     kind;
        logic [7:0] payload_byte;
        logic       last;
    } result_t;

endpackage

// ===== rtl/core/swld_in_reg.sv =====
module swld_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // rx_byte
    input  logic          s_tuser,   // kind
    input  logic          advance,
    output logic          item_valid,
    output swld_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    swld_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.kind    <= s_tuser;
            item_reg.rx_byte <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/swld_core.sv =====
module swld_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [swld_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                     proc_en,
    input  swld_pkg::item_t          item,
    output swld_pkg::result_t        res
);

    localparam int CNT_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

    logic [15:0]      timeout_reg;
    logic [15:0]      maxlen_reg;

    swld_pkg::phase_t phase_reg,    phase_next;
    logic [31:0]      window_reg,   window_next;
    logic [1:0]       lbs_reg,      lbs_next;
    logic [31:0]      lval_reg,     lval_next;
    logic [CNT_W-1:0] left_reg,     left_next;
    logic [15:0]      wd_count_reg, wd_count_next;
    logic             armed_reg,    armed_next;

    logic [31:0]      window_shift;
    logic [31:0]      lval_acc;
    logic [15:0]      wd_inc;
    logic [CNT_W-1:0] left_dec;
    logic             len_too_wide;
    logic             len_over_max;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= swld_pkg::TIMEOUT_RESET;
            maxlen_reg  <= swld_pkg::MAXLEN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                swld_pkg::CFG_TIMEOUT_TICKS: timeout_reg <= cfg_wdata;
                swld_pkg::CFG_MAX_LENGTH:    maxlen_reg  <= cfg_wdata;
                default:                     ;
            endcase
        end
    end

    assign window_shift = {item.rx_byte, window_reg[31:8]};
    assign lval_acc     = lval_reg | (32'(item.rx_byte) << {lbs_reg, 3'b000});
    assign wd_inc       = (wd_count_reg < swld_pkg::COUNT_MAX) ? wd_count_reg + 16'd1
                                                               : wd_count_reg;
    assign left_dec     = left_reg - CNT_W'(1);
    assign len_over_max = (|lval_acc[31:16]) || (lval_acc[15:0] > maxlen_reg);

    generate
        if (LENGTH_BITS >= 32) begin : g_full_len
            assign len_too_wide = 1'b0;
        end else begin : g_cap_len
            assign len_too_wide = |lval_acc[31:LENGTH_BITS];
        end
    endgenerate

    always_comb begin
        phase_next    = phase_reg;
        window_next   = window_reg;
        lbs_next      = lbs_reg;
        lval_next     = lval_reg;
        left_next     = left_reg;
        wd_count_next = wd_count_reg;
        armed_next    = armed_reg;
        res           = '0;
        res.kind      = swld_pkg::RK_PAYLOAD;

        if (item.kind == swld_pkg::KIND_TICK) begin
            if (armed_reg) begin
                wd_count_next = wd_inc;
                if (wd_inc >= timeout_reg) begin
                    armed_next = 1'b0;
                    res.valid  = 1'b1;
                    res.kind   = swld_pkg::RK_TIMEOUT;
                end
            end
        end else begin
            case (phase_reg)
                swld_pkg::PH_LEN: begin
                    lval_next = lval_acc;
                    if (lbs_reg != 2'd3) begin
                        lbs_next = lbs_reg + 2'd1;
                    end else begin
                        lbs_next = 2'd0;
                        if (lval_acc == 32'd0) begin
                            phase_next    = swld_pkg::PH_HUNT;
                            window_next   = '0;
                            wd_count_next = '0;
                            armed_next    = 1'b1;
                            res.valid     = 1'b1;
                            res.kind      = swld_pkg::RK_EMPTY;
                            res.last      = 1'b1;
                        end else if (len_over_max || len_too_wide) begin
                            phase_next  = swld_pkg::PH_HUNT;
                            window_next = '0;
                            res.valid   = 1'b1;
                            res.kind    = swld_pkg::RK_OVERSIZE;
                        end else begin
                            left_next  = lval_acc[CNT_W-1:0];
                            phase_next = swld_pkg::PH_PAY;
                        end
                    end
                end
                swld_pkg::PH_PAY: begin
                    left_next        = left_dec;
                    res.valid        = 1'b1;
                    res.payload_byte = item.rx_byte;
                    if (left_dec == '0) begin
                        phase_next    = swld_pkg::PH_HUNT;
                        window_next   = '0;
                        wd_count_next = '0;
                        armed_next    = 1'b1;
                        res.last      = 1'b1;
                    end
                end
                default: begin
                    if (window_shift == swld_pkg::SYNC_WORD) begin
                        window_next = '0;
                        phase_next  = swld_pkg::PH_LEN;
                        lbs_next    = 2'd0;
                        lval_next   = '0;
                    end else begin
                        window_next = window_shift;
                        phase_next  = swld_pkg::PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= swld_pkg::PH_HUNT;
            window_reg   <= '0;
            lbs_reg      <= '0;
            lval_reg     <= '0;
            left_reg     <= '0;
            wd_count_reg <= '0;
            armed_reg    <= 1'b1;
        end else if (proc_en) begin
            phase_reg    <= phase_next;
            window_reg   <= window_next;
            lbs_reg      <= lbs_next;
            lval_reg     <= lval_next;
            left_reg     <= left_next;
            wd_count_reg <= wd_count_next;
            armed_reg    <= armed_next;
        end
    end

    // payload results only come out of the payload phase
    a_payload_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en && res.valid && res.kind == swld_pkg::RK_PAYLOAD
        |-> phase_reg == swld_pkg::PH_PAY)
        else $error("payload result outside payload phase");

    a_timeout_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en && res.valid && res.kind == swld_pkg::RK_TIMEOUT
        |=> !armed_reg)
        else $error("watchdog still armed after timeout");

    a_last_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en && res.valid && res.last
        |=> armed_reg && wd_count_reg == 16'd0 && phase_reg == swld_pkg::PH_HUNT)
        else $error("completed frame did not re-arm watchdog");

    a_tick_keeps_framing: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en && item.kind == swld_pkg::KIND_TICK
        |=> $stable(phase_reg) && $stable(window_reg) && $stable(left_reg))
        else $error("tick changed deframing state");

endmodule

// ===== rtl/core/swld_out_reg.sv =====
module swld_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  swld_pkg::result_t res,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // payload_byte
    output logic [1:0]        m_tuser,   // result_kind
    output logic              m_tlast    // last_of_frame
);

    logic              valid_reg;
    logic              valid_next;
    swld_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = res.valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.payload_byte;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule

// ===== rtl/core/sync_word_length_deframer.sv =====
// Sync-word, length-prefixed frame deframer. Input transfers carry either a
// received byte (s_tuser low) or one time tick (s_tuser high). The byte stream
// is searched for the sync word AA 55 AA 55, a 4-byte little-endian length
// follows, then that many payload bytes come out with m_tlast on the final one
// (acknowledgment due). m_tuser gives the result kind: 0 payload byte, 1 empty
// frame, 2 oversize length dropped, 3 watchdog timeout. One transfer is
// accepted per clock while s_tready is high; it passes through the input
// register, the single-pass compare/count logic and the result register
// before its result is presented on the m_ side. s_tready falls only while
// both registers are full and m_tready is low. Configuration is written
// through cfg_wr_en/cfg_index/cfg_wdata (0 timeout_ticks, 1 max_length); the
// user must write it only while the block is idle, not enforced by the block.
module sync_word_length_deframer #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte
    input  logic        s_tuser,    // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // payload_byte
    output logic [1:0]  m_tuser,    // result_kind
    output logic        m_tlast,    // last_of_frame
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic              item_valid;
    swld_pkg::item_t   item;
    swld_pkg::result_t res;
    logic              out_free;
    logic              proc_en;

    assign proc_en = item_valid && out_free;

    swld_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (proc_en),
        .item_valid (item_valid),
        .item       (item)
    );

    swld_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .proc_en   (proc_en),
        .item      (item),
        .res       (res)
    );

    swld_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proc_en),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        swld_pkg::rkind_t kind;
        logic [7:0]       data;
        logic             last;
    } deframed_t;

    typedef struct packed {
        logic      kind;
        logic [7:0] data;
        logic      typed;
        deframed_t want;
    } stim_row_t;

    localparam deframed_t NO_RESULT = '{swld_pkg::RK_PAYLOAD, 8'h00, 1'b0};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    sync_word_length_deframer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predicted deframer state
    logic [15:0]       cfg_timeout;
    logic [15:0]       cfg_maxlen;
    swld_pkg::phase_t  df_phase;
    logic [31:0]       sync_window;
    logic [1:0]        len_seen;
    logic [31:0]       len_val;
    logic [15:0]       bytes_left;
    logic [15:0]       wd_count;
    logic              wd_armed;

    deframed_t deframed_q[$];
    stim_row_t pending_q[$];
    int        mismatches;
    int        items_sent;
    int        cycles;
    int        src_idle;
    int        sink_stall;

    // timeout, idle tick, sync, oversize by width, sync, empty frame, timeout, sync, payload 00 FF
    stim_row_t stim_rows [0:28] = '{
        '{swld_pkg::KIND_TICK, 8'h00, 1'b1, '{swld_pkg::RK_TIMEOUT, 8'h00, 1'b0}},
        '{swld_pkg::KIND_TICK, 8'hFF, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'hAA, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h55, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'hAA, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h55, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h01, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h00, 1'b1, '{swld_pkg::RK_OVERSIZE, 8'h00, 1'b0}},
        '{swld_pkg::KIND_BYTE, 8'hAA, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h55, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'hAA, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h55, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h00, 1'b1, '{swld_pkg::RK_EMPTY, 8'h00, 1'b1}},
        '{swld_pkg::KIND_TICK, 8'h00, 1'b1, '{swld_pkg::RK_TIMEOUT, 8'h00, 1'b0}},
        '{swld_pkg::KIND_BYTE, 8'hAA, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h55, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'hAA, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h55, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h02, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'h00, 1'b0, NO_RESULT},
        '{swld_pkg::KIND_BYTE, 8'hFF, 1'b1, '{swld_pkg::RK_PAYLOAD, 8'hFF, 1'b1}}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall);
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void close_frame();
        df_phase    = swld_pkg::PH_HUNT;
        sync_window = 32'h0;
        wd_count    = 16'h0;
        wd_armed    = 1'b1;
    endfunction

    function automatic bit deframe_step(input logic kind, input logic [7:0] b,
                                        output deframed_t res);
        res = NO_RESULT;
        if (kind == swld_pkg::KIND_TICK) begin
            if (!wd_armed)
                return 1'b0;
            if (wd_count != swld_pkg::COUNT_MAX)
                wd_count++;
            if (wd_count >= cfg_timeout) begin
                wd_armed = 1'b0;
                res.kind = swld_pkg::RK_TIMEOUT;
                return 1'b1;
            end
            return 1'b0;
        end
        case (df_phase)
            swld_pkg::PH_LEN: begin
                len_val |= 32'(b) << (8 * len_seen);
                if (len_seen != 2'd3) begin
                    len_seen++;
                    return 1'b0;
                end
                len_seen = 2'd0;
                if (len_val == 32'h0) begin
                    close_frame();
                    res.kind = swld_pkg::RK_EMPTY;
                    res.last = 1'b1;
                    return 1'b1;
                end
                if (len_val > {16'h0, cfg_maxlen} || len_val > 32'h0000_FFFF) begin
                    df_phase    = swld_pkg::PH_HUNT;
                    sync_window = 32'h0;
                    res.kind    = swld_pkg::RK_OVERSIZE;
                    return 1'b1;
                end
                bytes_left = len_val[15:0];
                df_phase   = swld_pkg::PH_PAY;
                return 1'b0;
            end
            swld_pkg::PH_PAY: begin
                bytes_left--;
                res.data = b;
                if (bytes_left == 16'h0) begin
                    close_frame();
                    res.last = 1'b1;
                end
                return 1'b1;
            end
            default: begin
                sync_window = {b, sync_window[31:8]};
                if (sync_window == swld_pkg::SYNC_WORD) begin
                    sync_window = 32'h0;
                    df_phase    = swld_pkg::PH_LEN;
                    len_seen    = 2'd0;
                    len_val     = 32'h0;
                end else begin
                    df_phase = swld_pkg::PH_HUNT;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // results first, then the input transfer of the same edge
    always @(posedge aclk) begin : check_results
        deframed_t want;
        deframed_t pred;
        stim_row_t row;
        bit        has;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (deframed_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result kind %0d data %02h last %0b",
                                            m_tuser, m_tdata, m_tlast));
                end else begin
                    want = deframed_q.pop_front();
                    if (m_tuser !== want.kind || m_tdata !== want.data
                            || m_tlast !== want.last)
                        flag_mismatch($sformatf(
                            "got kind %0d data %02h last %0b, wanted %0d %02h %0b",
                            m_tuser, m_tdata, m_tlast, want.kind, want.data, want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                row = pending_q.pop_front();
                has = deframe_step(s_tuser, s_tdata, pred);
                if (row.typed)
                    deframed_q.push_back(row.want);
                else if (has)
                    deframed_q.push_back(pred);
            end
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] b, input logic typed,
                             input deframed_t want);
        stim_row_t row;
        row = '{kind, b, typed, want};
        @(negedge aclk);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            @(negedge aclk);
        end
        pending_q.push_back(row);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < 8)
            send_item(swld_pkg::KIND_TICK, 8'($urandom), 1'b0, NO_RESULT);
        send_item(swld_pkg::KIND_BYTE, b, 1'b0, NO_RESULT);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic settle();
        while (deframed_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == swld_pkg::CFG_TIMEOUT_TICKS)
            cfg_timeout = val;
        else
            cfg_maxlen = val;
    endtask

    task automatic random_traffic(input int count);
        int          first;
        int          pick;
        int          n;
        logic [31:0] len;
        first = items_sent;
        while (items_sent - first < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                for (int i = 0; i < 4; i++)
                    send_byte(swld_pkg::SYNC_WORD[8*i +: 8]);
                pick = $urandom_range(99);
                if (pick < 10)
                    len = 32'h0;
                else if (pick < 70 && cfg_maxlen != 16'h0)
                    len = $urandom_range(1, (cfg_maxlen < 16) ? cfg_maxlen : 16);
                else if (pick < 85 && cfg_maxlen != 16'hFFFF)
                    len = $urandom_range(int'(cfg_maxlen) + 1, 65535);
                else begin
                    len = $urandom;
                    if (len[31:16] == 16'h0)
                        len[16] = 1'b1;
                end
                for (int i = 0; i < 4; i++)
                    send_byte(len[8*i +: 8]);
                if (len != 32'h0 && len <= {16'h0, cfg_maxlen})
                    for (int i = 0; i < int'(len); i++)
                        send_byte(8'($urandom));
            end else if (pick < 80) begin
                // broken sync followed by a stray byte
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    send_byte(swld_pkg::SYNC_WORD[8*i +: 8]);
                send_byte(8'($urandom));
            end else if (pick < 90) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom));
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_item(swld_pkg::KIND_TICK, 8'($urandom), 1'b0, NO_RESULT);
            end
        end
        stop_sending();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tuser     = swld_pkg::KIND_BYTE;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = swld_pkg::CFG_TIMEOUT_TICKS;
        cfg_wdata   = 16'h0;
        src_idle    = 0;
        sink_stall  = 0;
        mismatches  = 0;
        items_sent  = 0;
        cycles      = 0;
        cfg_timeout = swld_pkg::TIMEOUT_RESET;
        cfg_maxlen  = swld_pkg::MAXLEN_RESET;
        df_phase    = swld_pkg::PH_HUNT;
        sync_window = 32'h0;
        len_seen    = 2'd0;
        len_val     = 32'h0;
        bytes_left  = 16'h0;
        wd_count    = 16'h0;
        wd_armed    = 1'b1;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero timeout fires on first armed tick
        write_reg(swld_pkg::CFG_TIMEOUT_TICKS, 16'h0000);
        write_reg(swld_pkg::CFG_MAX_LENGTH, 16'hFFFF);
        foreach (stim_rows[i])
            send_item(stim_rows[i].kind, stim_rows[i].data, stim_rows[i].typed,
                      stim_rows[i].want);
        stop_sending();
        settle();

        write_reg(swld_pkg::CFG_TIMEOUT_TICKS, 16'd3);
        write_reg(swld_pkg::CFG_MAX_LENGTH, 16'd8);
        random_traffic(380);
        settle();

        write_reg(swld_pkg::CFG_TIMEOUT_TICKS, 16'd1);
        write_reg(swld_pkg::CFG_MAX_LENGTH, 16'd0);
        src_idle = 55;
        random_traffic(380);
        settle();

        write_reg(swld_pkg::CFG_TIMEOUT_TICKS, 16'd40);
        write_reg(swld_pkg::CFG_MAX_LENGTH, 16'd20);
        src_idle   = 0;
        sink_stall = 55;
        random_traffic(380);
        settle();

        write_reg(swld_pkg::CFG_TIMEOUT_TICKS, 16'd1000);
        write_reg(swld_pkg::CFG_MAX_LENGTH, 16'hFFFF);
        src_idle   = 12;
        sink_stall = 12;
        random_traffic(380);
        settle();

        // empty frame re-arms the watchdog, then a run of ticks past the limit
        write_reg(swld_pkg::CFG_TIMEOUT_TICKS, 16'd5);
        src_idle   = 0;
        sink_stall = 0;
        for (int i = 0; i < 4; i++)
            send_item(swld_pkg::KIND_BYTE, swld_pkg::SYNC_WORD[8*i +: 8], 1'b0, NO_RESULT);
        for (int i = 0; i < 4; i++)
            send_item(swld_pkg::KIND_BYTE, 8'h00, 1'b0, NO_RESULT);
        for (int i = 0; i < 8; i++)
            send_item(swld_pkg::KIND_TICK, 8'($urandom), 1'b0, NO_RESULT);
        stop_sending();
        settle();

        if (deframed_q.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    deframed_q.size()));
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/swld_pkg.sv
rtl/core/swld_in_reg.sv
rtl/core/swld_core.sv
rtl/core/swld_out_reg.sv
rtl/core/sync_word_length_deframer.sv
sim/testbench.sv
